[sv/rcop_pkg.sv]
`default_nettype none

package rcop_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TUNNEL_MODE = 2'd0,
        CFG_CSUM_ENABLE = 2'd1,
        CFG_GSO_ENABLE  = 2'd2
    } cfg_index_t;

    localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ   = 16'h88A8;
    localparam logic [15:0] ETYPE_VLAN_A = 16'h9100;
    localparam logic [15:0] ETYPE_VLAN_B = 16'h9200;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;

    localparam logic [7:0] VER_MASK = 8'hF0;
    localparam logic [7:0] VER_IPV4 = 8'h40;
    localparam logic [7:0] VER_IPV6 = 8'h60;

    localparam logic [4:0] L2_SIZE_PLAIN = 5'd14;
    localparam logic [4:0] L2_SIZE_ONE   = 5'd18;
    localparam logic [4:0] L2_SIZE_TWO   = 5'd22;

    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_TAG1_HI  = 16'd16;
    localparam logic [15:0] POS_TAG1_LO  = 16'd17;
    localparam logic [15:0] POS_TAG2_HI  = 16'd20;
    localparam logic [15:0] POS_TAG2_LO  = 16'd21;

    localparam logic [6:0] REL_V4_PROTO = 7'd9;
    localparam logic [6:0] REL_V6_NEXT  = 7'd6;
    localparam logic [6:0] REL_TCP_DOFF = 7'd12;
    localparam logic [6:0] V6_HDR_LEN   = 7'd40;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [5:0] UDP_HDR_LEN = 6'd8;

    localparam logic [7:0] GSO_TCPV4 = 8'd1;
    localparam logic [7:0] GSO_TCPV6 = 8'd4;

    typedef struct packed {
        logic tunnel_mode;
        logic csum_offload_enable;
        logic gso_enable;
    } cfg_t;

    typedef struct packed {
        logic [15:0] ether_kind;
        logic [4:0]  l2_size;
        logic [3:0]  ip_hdr_words;
        logic [7:0]  proto_seen;
        logic [3:0]  tcp_data_offset;
        logic [7:0]  held_hi;
        logic [15:0] next_pos;
        logic        needs_csum;
        logic [7:0]  gso_kind;
        logic [15:0] gso_segment;
    } pkt_rec_t;

    typedef struct packed {
        logic [15:0] packet_length;
        logic [15:0] gso_size_out;
        logic        gso_active;
        logic [2:0]  offload_flags;
        logic        offsets_valid;
        logic        is_ip6;
        logic        is_ip4;
        logic [5:0]  l4_hdr_size;
        logic [7:0]  l4_proto;
        logic [6:0]  l4_offset;
        logic [4:0]  l3_offset;
    } result_t;

    function automatic logic is_tag_type(input logic [15:0] t);
        return (t == ETYPE_VLAN) || (t == ETYPE_QINQ) ||
               (t == ETYPE_VLAN_A) || (t == ETYPE_VLAN_B);
    endfunction

    function automatic logic l2_is_done(input logic tunnel, input logic [4:0] l2,
                                        input logic [15:0] kind);
        return tunnel ||
               ((l2 == L2_SIZE_PLAIN) && !is_tag_type(kind)) ||
               ((l2 == L2_SIZE_ONE) && (kind != ETYPE_VLAN)) ||
               (l2 == L2_SIZE_TWO);
    endfunction

endpackage

`default_nettype wire

[sv/rcop_front.sv]
`default_nettype none

module rcop_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rcop_pkg::cfg_t    cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              first_flag,
    input  wire logic              last_flag,
    input  wire logic              needs_csum,
    input  wire logic [7:0]        gso_kind,
    input  wire logic [15:0]       gso_segment,
    output logic                   rec_valid,
    output rcop_pkg::pkt_rec_t     rec,
    input  wire logic              rec_ready
);
    import rcop_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] kind_reg, kind_next;
    logic [4:0]  l2_reg, l2_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [3:0]  tcp_reg, tcp_next;
    logic [7:0]  held_reg, held_next;
    logic        needs_reg, needs_next;
    logic [7:0]  gkind_reg, gkind_next;
    logic [15:0] gseg_reg, gseg_next;

    logic        accept;
    logic [15:0] pos, pos_inc, rel;
    logic [15:0] p_kind;
    logic [4:0]  p_l2;
    logic [3:0]  p_ihl, p_tcp;
    logic [7:0]  p_proto, p_held, p_nib;
    logic [6:0]  l4rel;
    logic        is_v4, is_v6;

    assign in_ready = rec_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        pos     = first_flag ? '0 : pos_reg;
        p_kind  = first_flag ? '0 : kind_reg;
        p_l2    = first_flag ? '0 : l2_reg;
        p_ihl   = first_flag ? '0 : ihl_reg;
        p_proto = first_flag ? '0 : proto_reg;
        p_tcp   = first_flag ? '0 : tcp_reg;
        p_held  = first_flag ? '0 : held_reg;
        p_nib   = data_byte & VER_MASK;

        if (cfg.tunnel_mode) begin
            if (pos == '0) begin
                p_kind = (p_nib == VER_IPV4) ? ETYPE_IPV4 :
                         (p_nib == VER_IPV6) ? ETYPE_IPV6 : '0;
                p_l2   = '0;
            end
        end else if ((pos == POS_ETYPE_HI) || (pos == POS_TAG1_HI) ||
                     (pos == POS_TAG2_HI)) begin
            p_held = data_byte;
        end else if (pos == POS_ETYPE_LO) begin
            p_kind = {p_held, data_byte};
            p_l2   = L2_SIZE_PLAIN;
        end else if ((pos == POS_TAG1_LO) && (p_l2 == L2_SIZE_PLAIN) &&
                     is_tag_type(p_kind)) begin
            p_kind = {p_held, data_byte};
            p_l2   = L2_SIZE_ONE;
        end else if ((pos == POS_TAG2_LO) && (p_l2 == L2_SIZE_ONE) &&
                     (p_kind == ETYPE_VLAN)) begin
            p_kind = {p_held, data_byte};
            p_l2   = L2_SIZE_TWO;
        end

        rel   = pos - {11'b0, p_l2};
        is_v4 = (p_kind == ETYPE_IPV4);
        is_v6 = (p_kind == ETYPE_IPV6);
        l4rel = V6_HDR_LEN;
        if (l2_is_done(cfg.tunnel_mode, p_l2, p_kind) && (pos >= {11'b0, p_l2})) begin
            if (is_v4) begin
                if (rel == '0) begin
                    p_ihl = data_byte[3:0];
                end
                if (rel == {9'b0, REL_V4_PROTO}) begin
                    p_proto = data_byte;
                end
                l4rel = {1'b0, p_ihl, 2'b00};
            end else if (is_v6) begin
                if (rel == {9'b0, REL_V6_NEXT}) begin
                    p_proto = data_byte;
                end
            end
            if ((is_v4 || is_v6) && (rel == {9'b0, l4rel + REL_TCP_DOFF})) begin
                p_tcp = data_byte[7:4];
            end
        end

        pos_inc = (pos != '1) ? pos + 16'd1 : pos;
    end

    always_comb begin
        needs_next = needs_reg;
        gkind_next = gkind_reg;
        gseg_next  = gseg_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        l2_next    = l2_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        tcp_next   = tcp_reg;
        held_next  = held_reg;
        if (accept) begin
            if (first_flag) begin
                needs_next = needs_csum;
                gkind_next = gso_kind;
                gseg_next  = gso_segment;
            end
            if (last_flag) begin
                pos_next   = '0;
                kind_next  = '0;
                l2_next    = '0;
                ihl_next   = '0;
                proto_next = '0;
                tcp_next   = '0;
                held_next  = '0;
            end else begin
                pos_next   = pos_inc;
                kind_next  = p_kind;
                l2_next    = p_l2;
                ihl_next   = p_ihl;
                proto_next = p_proto;
                tcp_next   = p_tcp;
                held_next  = p_held;
            end
        end
    end

    always_comb begin
        rec_valid           = accept && last_flag;
        rec.ether_kind      = p_kind;
        rec.l2_size         = p_l2;
        rec.ip_hdr_words    = p_ihl;
        rec.proto_seen      = p_proto;
        rec.tcp_data_offset = p_tcp;
        rec.held_hi         = p_held;
        rec.next_pos        = pos_inc;
        rec.needs_csum      = first_flag ? needs_csum : needs_reg;
        rec.gso_kind        = first_flag ? gso_kind : gkind_reg;
        rec.gso_segment     = first_flag ? gso_segment : gseg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            kind_reg  <= '0;
            l2_reg    <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            tcp_reg   <= '0;
            held_reg  <= '0;
            needs_reg <= 1'b0;
            gkind_reg <= '0;
            gseg_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            l2_reg    <= l2_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            tcp_reg   <= tcp_next;
            held_reg  <= held_next;
            needs_reg <= needs_next;
            gkind_reg <= gkind_next;
            gseg_reg  <= gseg_next;
        end
    end

endmodule

`default_nettype wire

[sv/rcop_fifo.sv]
`default_nettype none

module rcop_fifo #(
    parameter int DEPTH = rcop_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire rcop_pkg::pkt_rec_t push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output rcop_pkg::pkt_rec_t      pop_data
);
    import rcop_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_rec_t             stor_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = stor_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            stor_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/rcop_back.sv]
`default_nettype none

module rcop_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rcop_pkg::cfg_t     cfg,
    input  wire logic               rec_valid,
    output logic                    rec_ready,
    input  wire rcop_pkg::pkt_rec_t rec,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output rcop_pkg::result_t       res
);
    import rcop_pkg::*;

    logic     valid_reg, valid_next;
    result_t  res_reg, res_next;

    logic [15:0] kind_f, held_word, plen;
    logic [4:0]  l2_f;
    logic        done_f, is_v4, is_v6;
    logic [3:0]  ihl_f, tcp_f;
    logic [7:0]  proto_f, proto;
    logic [6:0]  c_proto, c_tcp, l4rel;
    logic        load;

    assign rec_ready = !valid_reg || res_ready;
    assign load      = rec_valid && rec_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // Resolve the header bytes that lie past the end of the packet as zeros.
    always_comb begin
        plen      = rec.next_pos;
        held_word = {rec.held_hi, 8'h00};
        kind_f    = rec.ether_kind;
        l2_f      = rec.l2_size;
        if (!cfg.tunnel_mode) begin
            if (plen <= POS_ETYPE_LO) begin
                kind_f = (plen == POS_ETYPE_LO) ? held_word : '0;
                l2_f   = L2_SIZE_PLAIN;
            end
            if ((plen <= POS_TAG1_LO) && (l2_f == L2_SIZE_PLAIN) && is_tag_type(kind_f)) begin
                kind_f = (plen == POS_TAG1_LO) ? held_word : '0;
                l2_f   = L2_SIZE_ONE;
            end
            if ((plen <= POS_TAG2_LO) && (l2_f == L2_SIZE_ONE) && (kind_f == ETYPE_VLAN)) begin
                kind_f = (plen == POS_TAG2_LO) ? held_word : '0;
                l2_f   = L2_SIZE_TWO;
            end
        end
        done_f = l2_is_done(cfg.tunnel_mode, l2_f, kind_f);
        is_v4  = (kind_f == ETYPE_IPV4);
        is_v6  = (kind_f == ETYPE_IPV6);

        ihl_f = (done_f && is_v4 && ({11'b0, l2_f} >= plen)) ? '0 : rec.ip_hdr_words;
        c_proto = {2'b0, l2_f} + (is_v4 ? REL_V4_PROTO : REL_V6_NEXT);
        proto_f = (done_f && (is_v4 || is_v6) && ({9'b0, c_proto} >= plen)) ?
                  '0 : rec.proto_seen;
        l4rel = is_v4 ? {1'b0, ihl_f, 2'b00} : V6_HDR_LEN;
        c_tcp = {2'b0, l2_f} + l4rel + REL_TCP_DOFF;
        tcp_f = (done_f && (is_v4 || is_v6) && ({9'b0, c_tcp} >= plen)) ?
                '0 : rec.tcp_data_offset;
    end

    always_comb begin
        res_next = res_reg;
        proto    = '0;
        if (load) begin
            res_next = '0;
            if (cfg.csum_offload_enable && rec.needs_csum) begin
                res_next.l3_offset = l2_f;
                if (is_v4 || is_v6) begin
                    proto                        = proto_f;
                    res_next.l4_offset           = {2'b0, l2_f} + l4rel;
                    res_next.l4_proto            = proto_f;
                    res_next.offsets_valid       = 1'b1;
                    res_next.is_ip4              = is_v4;
                    res_next.is_ip6              = is_v6;
                    res_next.offload_flags[0]    = is_v4;
                end
                if (proto == PROTO_TCP) begin
                    res_next.offload_flags[1] = 1'b1;
                    res_next.l4_hdr_size      = {tcp_f, 2'b00};
                end else if (proto == PROTO_UDP) begin
                    res_next.offload_flags[2] = 1'b1;
                    res_next.l4_hdr_size      = UDP_HDR_LEN;
                end
            end
            if (cfg.gso_enable) begin
                if (rec.gso_kind == GSO_TCPV4) begin
                    res_next.gso_active   = 1'b1;
                    res_next.gso_size_out = rec.gso_segment;
                    res_next.is_ip4       = 1'b1;
                end else if (rec.gso_kind == GSO_TCPV6) begin
                    res_next.gso_active   = 1'b1;
                    res_next.gso_size_out = rec.gso_segment;
                    res_next.is_ip6       = 1'b1;
                end
            end
            res_next.packet_length = plen;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

[sv/rx_checksum_offload_header_parser.sv]
// Receive-side header parser that produces checksum and segmentation offload
// metadata, one result word per packet.
// The s_ channel carries one packet byte per word: s_tuser marks the first byte
// of a packet, s_tlast the last, and the virtio header fields ride in s_tdata
// and are sampled on the first byte. The m_ channel gives one result word per
// packet with m_tlast always high. The cfg_ channel writes the tunnel mode,
// checksum enable and segmentation enable bits; it is always ready.
// Bytes are taken at one per cycle while the queue has room. The parse state
// advances as each byte arrives; header fields missing from short packets read as zeros.
// A packet's record passes through the queue and then the result register to
// m_tvalid; results can follow each other in consecutive cycles while m_tready is high.
// A two-entry queue sits between the byte parser and the result stage, so the
// parser keeps taking bytes while m_tready is low until the queue holds two
// finished packets; s_tready then drops until a result is taken.
// Synchronous reset clears the configuration bits, the parse state, the
// sampled virtio fields and the queue; the block is ready on the first cycle
// after reset.
`default_nettype none

module rx_checksum_offload_header_parser #(
    parameter int QUEUE_DEPTH = rcop_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // data_byte, needs_csum, gso_kind, gso_segment, zero fill.
    input  wire logic [39:0]                      s_tdata,
    // first_flag.
    input  wire logic                             s_tuser,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // l3_offset, l4_offset, l4_proto, l4_hdr_size, is_ip4, is_ip6, offsets_valid,
    // offload_flags, gso_active, gso_size_out, packet_length, zero fill.
    output logic [71:0]                           m_tdata,
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rcop_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic                             cfg_data
);
    import rcop_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      fq_push_valid, fq_push_ready, fq_pop_valid, fq_pop_ready;
    pkt_rec_t  fq_push_data, fq_pop_data;
    result_t   res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TUNNEL_MODE: cfg_next.tunnel_mode         = cfg_data;
                CFG_CSUM_ENABLE: cfg_next.csum_offload_enable = cfg_data;
                CFG_GSO_ENABLE:  cfg_next.gso_enable          = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rcop_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_byte   (s_tdata[7:0]),
        .first_flag  (s_tuser),
        .last_flag   (s_tlast),
        .needs_csum  (s_tdata[8]),
        .gso_kind    (s_tdata[16:9]),
        .gso_segment (s_tdata[32:17]),
        .rec_valid   (fq_push_valid),
        .rec         (fq_push_data),
        .rec_ready   (fq_push_ready)
    );

    rcop_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_push_valid),
        .push_ready (fq_push_ready),
        .push_data  (fq_push_data),
        .pop_valid  (fq_pop_valid),
        .pop_ready  (fq_pop_ready),
        .pop_data   (fq_pop_data)
    );

    rcop_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec_valid (fq_pop_valid),
        .rec_ready (fq_pop_ready),
        .rec       (fq_pop_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'b0, res.packet_length, res.gso_size_out, res.gso_active,
                      res.offload_flags, res.offsets_valid, res.is_ip6, res.is_ip4,
                      res.l4_hdr_size, res.l4_proto, res.l4_offset, res.l3_offset};
    assign m_tlast = 1'b1;

endmodule

`default_nettype wire
